### rtl/ppdc_pkg.sv
package ppdc_pkg;

    localparam int unsigned CLOCK_W = 28;
    localparam int unsigned FREQ_W  = 18;
    localparam int unsigned COUNT_W = 16;

    localparam logic [CLOCK_W-1:0] CLOCK_RESET = 28'd80000000;
    localparam logic [FREQ_W-1:0]  FREQ_MAX    = 18'd250000;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_NOFIT = 2'd2;

    localparam logic [2:0] CODE_LAST = 3'd7;

    typedef struct packed {
        logic [FREQ_W-1:0]  req_freq;
        logic [COUNT_W-1:0] duty_frac;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [2:0]         prescale_code;
        logic [COUNT_W-1:0] period;
        logic [COUNT_W-1:0] compare;
    } t_out_item;

    // log2 of the divider set 1,2,4,8,16,32,64,256
    function automatic logic [3:0] div_shift(input logic [2:0] code);
        logic [3:0] sh;
        sh = (code == CODE_LAST) ? 4'd8 : {1'b0, code};
        return sh;
    endfunction

endpackage

### rtl/pwm_prescale_period_duty_calc.sv
// PWM prescaler, period and compare calculator.
//
// Input channel (i_in_valid / o_in_ready, payload i_in_data) takes a requested
// frequency and a 16-bit duty fraction. Output channel (o_out_valid /
// i_out_ready, payload o_out_data) returns status, prescaler code, period and
// compare value. Config channel (i_cfg_valid / o_cfg_ready, i_cfg_data) sets
// the peripheral clock in hertz; it is always ready.
//
// An accepted item passes through a restoring divider (one quotient bit a cycle,
// clock / frequency), a shared shifter that tries the prescalers in order, the
// 16x16 duty multiply and the load of the output register.
// A frequency out of range skips straight to the result.
// The block takes one item at a time: o_in_ready is high only while idle.
//
// The output register parts the two sides: a new item is accepted while a
// result still waits. If the receiver stalls, the next finished item waits in
// the sequencer's last step until the output register frees.
// Reset returns the sequencer to idle, empties the output register and sets
// the clock register to 80000000.
module pwm_prescale_period_duty_calc (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ppdc_pkg::t_in_item i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ppdc_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [27:0]        i_cfg_data
);
    import ppdc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [4:0] DIV_LAST = 5'(CLOCK_W - 1);

    logic [2:0]           r_state, n_state;
    logic [CLOCK_W-1:0]   r_clock_hz;
    logic [CLOCK_W-1:0]   r_quo, n_quo;
    logic [FREQ_W-1:0]    r_rem, n_rem;
    logic [FREQ_W-1:0]    r_freq, n_freq;
    logic [COUNT_W-1:0]   r_duty, n_duty;
    logic [4:0]           r_cnt, n_cnt;
    logic [2:0]           r_code, n_code;
    logic [1:0]           r_status, n_status;
    logic [COUNT_W-1:0]   r_period, n_period;
    logic [2*COUNT_W-1:0] r_product, n_product;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;

    logic [FREQ_W:0]      trial;
    logic [FREQ_W:0]      trial_diff;
    logic [CLOCK_W-1:0]   shifted;
    logic                 in_xfer;
    logic                 out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    assign trial      = {r_rem, r_quo[CLOCK_W-1]};
    assign trial_diff = trial - {1'b0, r_freq};
    assign shifted    = r_quo >> div_shift(r_code);

    always_comb begin
        n_state     = r_state;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_freq      = r_freq;
        n_duty      = r_duty;
        n_cnt       = r_cnt;
        n_code      = r_code;
        n_status    = r_status;
        n_period    = r_period;
        n_product   = r_product;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_freq = i_in_data.req_freq;
                    n_duty = i_in_data.duty_frac;
                    n_quo  = r_clock_hz;
                    n_rem  = '0;
                    n_cnt  = '0;
                    n_code = '0;
                    if (i_in_data.req_freq == '0 || i_in_data.req_freq > FREQ_MAX) begin
                        n_status = STATUS_RANGE;
                        n_state  = ST_DONE;
                    end else begin
                        n_status = STATUS_OK;
                        n_state  = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                // restoring step: shift in the next dividend bit, subtract if it fits
                if (!trial_diff[FREQ_W]) begin
                    n_rem = trial_diff[FREQ_W-1:0];
                    n_quo = {r_quo[CLOCK_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[FREQ_W-1:0];
                    n_quo = {r_quo[CLOCK_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == DIV_LAST) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (shifted[CLOCK_W-1:COUNT_W] == '0) begin
                    n_period = shifted[COUNT_W-1:0];
                    n_state  = ST_MUL;
                end else if (r_code == CODE_LAST) begin
                    n_status = STATUS_NOFIT;
                    n_state  = ST_DONE;
                end else begin
                    n_code = r_code + 3'd1;
                end
            end
            ST_MUL: begin
                n_product = (2*COUNT_W)'(r_duty) * (2*COUNT_W)'(r_period);
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register can take the result
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out.status = r_status;
                    if (r_status == STATUS_OK) begin
                        n_out.prescale_code = r_code;
                        n_out.period        = r_period;
                        n_out.compare       = r_product[2*COUNT_W-1:COUNT_W];
                    end else begin
                        n_out.prescale_code = '0;
                        n_out.period        = '0;
                        n_out.compare       = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_clock_hz  <= CLOCK_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_clock_hz <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_freq    <= n_freq;
        r_duty    <= n_duty;
        r_cnt     <= n_cnt;
        r_code    <= n_code;
        r_status  <= n_status;
        r_period  <= n_period;
        r_product <= n_product;
        r_out     <= n_out;
    end

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_freq))
        else $error("divider remainder not below divisor");

    a_compare_le_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == STATUS_OK) |->
        (o_out_data.compare <= o_out_data.period))
        else $error("compare above period");

    a_error_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != STATUS_OK) |->
        (o_out_data.period == '0 && o_out_data.compare == '0 &&
         o_out_data.prescale_code == '0))
        else $error("error result with nonzero fields");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_in_ready)
        else $error("sequencer stayed idle after accept");

endmodule

### test/testbench.sv
module testbench;
    import ppdc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    in_data = '0;
    logic        o_out_valid;
    logic        out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [27:0] cfg_data = '0;

    pwm_prescale_period_duty_calc dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_in_item    pending_requests[$];
    t_out_item   pwm_expected[$];
    logic [27:0] clock_hz_now = CLOCK_RESET;
    int unsigned n_errors = 0;
    int unsigned n_sent = 0;
    int unsigned n_checked = 0;
    int unsigned n_clock_settings = 1;
    int unsigned n_drain_holds = 0;
    int unsigned cycle_count = 0;
    int unsigned status_seen [3] = '{0, 0, 0};
    logic [7:0]  codes_seen = '0;

    // period = floor(clock / freq) scaled by the first prescaler that fits 16 bits
    function automatic t_out_item calc_pwm_setting(t_in_item req, logic [27:0] clk_hz);
        t_out_item   res;
        logic [27:0] quot;
        logic [27:0] cnt;
        logic [31:0] prod;
        int unsigned sh;
        int          c;
        bit          hit;
        res = '0;
        if (req.req_freq == '0 || req.req_freq > FREQ_MAX) begin
            res.status = STATUS_RANGE;
            return res;
        end
        quot = clk_hz / req.req_freq;
        hit = 1'b0;
        for (c = 0; c < 8 && !hit; c++) begin
            sh = (c == 7) ? 8 : c;
            cnt = quot >> sh;
            if (cnt <= 28'h000ffff) begin
                hit = 1'b1;
                res.prescale_code = 3'(c);
                res.period = cnt[15:0];
            end
        end
        if (!hit) begin
            res.status = STATUS_NOFIT;
            return res;
        end
        res.status = STATUS_OK;
        prod = 32'(req.duty_frac) * 32'(res.period);
        res.compare = prod[31:16];
        return res;
    endfunction

    function automatic t_in_item random_request();
        t_in_item    req;
        int unsigned pick;
        int unsigned f;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            req.req_freq = '0;
        end else if (pick < 3) begin
            req.req_freq = 18'($urandom_range(250001, 262143));
        end else begin
            // log-spread so every prescaler gets picked
            f = $urandom_range(1, 250000) >> $urandom_range(0, 17);
            req.req_freq = 18'((f == 0) ? 1 : f);
        end
        pick = $urandom_range(0, 7);
        if (pick == 0) req.duty_frac = '0;
        else if (pick == 1) req.duty_frac = 16'hffff;
        else req.duty_frac = 16'($urandom);
        return req;
    endfunction

    function automatic void add_request(int unsigned freq, int unsigned duty);
        t_in_item req;
        req.req_freq = 18'(freq);
        req.duty_frac = 16'(duty);
        pending_requests.push_back(req);
    endfunction

    function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
        n_errors++;
        if (n_errors <= 10) begin
            $display("mismatch on %s: expected %0d, got %0d (result %0d)",
                     what, want, got, n_checked);
        end
    endfunction

    // sample between edges so the sender's updates have settled
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || in_valid || pwm_expected.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_clock(logic [27:0] hz);
        cfg_valid <= 1'b1;
        cfg_data  <= hz;
        do @(posedge i_clk);
        while (!(cfg_valid && o_cfg_ready));
        clock_hz_now = hz;
        n_clock_settings++;
        cfg_valid <= 1'b0;
    endtask

    // sender: bursts of random length, random gaps, occasional hold until drained
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    bit          drain_hold = 1'b0;

    always @(posedge i_clk) begin : sender
        logic fire;
        fire = in_valid && o_in_ready;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (fire) begin
                pwm_expected.push_back(calc_pwm_setting(in_data, clock_hz_now));
                n_sent++;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    if ($urandom_range(0, 3) == 0) gap_left = 0;
                    else if ($urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 60);
                    else gap_left = $urandom_range(1, 8);
                    if ($urandom_range(0, 29) == 0 || (n_drain_holds == 0 && n_sent > 25)) begin
                        drain_hold = 1'b1;
                        n_drain_holds++;
                    end
                end
            end
            if (!in_valid || fire) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (drain_hold && pwm_expected.size() != 0) begin
                    in_valid <= 1'b0;
                end else if (pending_requests.size() == 0) begin
                    in_valid <= 1'b0;
                end else begin
                    drain_hold = 1'b0;
                    in_valid <= 1'b1;
                    in_data  <= pending_requests.pop_front();
                end
            end
        end
    end

    // receiver: rotate a stall pattern, swap it out when its age counter runs out
    logic [7:0]  stall_pat = 8'hff;
    int unsigned pat_age = 0;

    always @(posedge i_clk) begin : receiver
        t_out_item want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (pwm_expected.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10) $display("result with nothing expected: %p", o_out_data);
                end else begin
                    want = pwm_expected.pop_front();
                    if (o_out_data.status !== want.status)
                        note_mismatch("status", want.status, o_out_data.status);
                    if (o_out_data.prescale_code !== want.prescale_code)
                        note_mismatch("prescale_code", want.prescale_code,
                                      o_out_data.prescale_code);
                    if (o_out_data.period !== want.period)
                        note_mismatch("period", want.period, o_out_data.period);
                    if (o_out_data.compare !== want.compare)
                        note_mismatch("compare", want.compare, o_out_data.compare);
                    if (want.status <= STATUS_NOFIT) status_seen[want.status]++;
                    if (want.status == STATUS_OK) codes_seen[want.prescale_code] = 1'b1;
                end
                n_checked++;
            end
            if (pat_age == 0) begin
                stall_pat = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom);
                pat_age = 31;
            end else begin
                pat_age--;
            end
            out_ready <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[7:1]};
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timed out after %0d cycles with %0d results outstanding",
                     cycle_count, pwm_expected.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stimulus
        logic [27:0] clock_plan [9];
        int          p;
        clock_plan[0] = 28'd200000000;
        clock_plan[1] = 28'd1;
        clock_plan[2] = 28'd0;
        clock_plan[3] = 28'hfffffff;
        clock_plan[4] = 28'd1000;
        clock_plan[5] = 28'($urandom_range(1, 200000000));
        clock_plan[6] = 28'($urandom_range(1, 100000));
        clock_plan[7] = 28'($urandom_range(1, 200000000));
        clock_plan[8] = CLOCK_RESET;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset clock of 80 MHz: range edges, every prescaler code but 2, no-fit, duty extremes
        add_request(0, 65535);
        add_request(1, 0);
        add_request(2, 65535);
        add_request(5, 65535);
        add_request(5, 0);
        add_request(9, 65535);
        add_request(20, 65535);
        add_request(39, 65535);
        add_request(100, 43690);
        add_request(305, 65535);
        add_request(1000, 21845);
        add_request(1220, 32768);
        add_request(1221, 65535);
        add_request(1222, 1);
        add_request(2441, 65535);
        add_request(10000, 65535);
        add_request(131072, 12345);
        add_request(200000, 0);
        add_request(250000, 65535);
        add_request(250001, 65535);
        add_request(262143, 65535);
        repeat (100) pending_requests.push_back(random_request());
        wait_drained();

        for (p = 0; p < 9; p++) begin
            program_clock(clock_plan[p]);
            repeat (110) pending_requests.push_back(random_request());
            wait_drained();
        end

        repeat (40) @(posedge i_clk);
        if (pwm_expected.size() != 0) begin
            n_errors++;
            $display("%0d expected results never arrived", pwm_expected.size());
        end
        $display("ran %0d requests through %0d clock settings (incl. 0, 1, 200 MHz, full scale)",
                 n_sent, n_clock_settings);
        $display("outcomes: %0d ok, %0d out of range, %0d no divider; prescaler codes hit %b",
                 status_seen[0], status_seen[1], status_seen[2], codes_seen);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
